[rtl/core/svpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_pkg: shared types and constants for the space vector PWM duty block
// Register indexes, sector codes, the phase wrap limit and the structs that
// pass between the sector unit, the duty unit and the top level.
// ----------------------------------------------------------------------------
package svpd_pkg;

  localparam int PHASE_W = 16;
  localparam int DUTY_W  = 16;
  localparam int ENTRY_W = 15;
  localparam int PER_W   = 15;
  localparam int SW_W    = 14;
  localparam int SEC_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int Q15_SHIFT  = 15;

  localparam logic [PHASE_W-1:0] PHASE_LIMIT = 16'hffdc;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_WIDTH = 2'd2;

  localparam logic [SEC_W-1:0] SECTOR_0 = 3'd0;
  localparam logic [SEC_W-1:0] SECTOR_1 = 3'd1;
  localparam logic [SEC_W-1:0] SECTOR_2 = 3'd2;
  localparam logic [SEC_W-1:0] SECTOR_3 = 3'd3;
  localparam logic [SEC_W-1:0] SECTOR_4 = 3'd4;
  localparam logic [SEC_W-1:0] SECTOR_5 = 3'd5;

  typedef struct packed {
    logic [SEC_W-1:0]   sector;
    logic [PHASE_W-1:0] ang1;
    logic [PHASE_W-1:0] ang2;
  } sect_ang_t;

  typedef struct packed {
    logic [DUTY_W-1:0] a;
    logic [DUTY_W-1:0] b;
    logic [DUTY_W-1:0] c;
  } duty_t;

endpackage

[rtl/core/space_vector_pwm_duty.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_duty: three-phase space vector PWM duty generator
// Advances a phase accumulator on each tick, looks up two sine values for the
// sector angles and produces three centre-aligned duty counts. Table-load
// transactions write the sine memory and produce no result.
// ----------------------------------------------------------------------------
//  channel | ports                                           | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, in_cmd, in_table_index,     | to block
//          | in_table_value                                  |
//  out     | out_valid, out_stall, out_duty_a/b/c, out_sector| from block
//  cfg     | cfg_wr_en, cfg_index, cfg_wr_data               | to block
//
//  One transaction is accepted per cycle while in_stall is low. A tick
//  passes input register, sine memory read, multiply and duty registers,
//  the last driving the outputs. Table writes take effect in the memory
//  stage, in order with ticks. Reset clears the phase and all valid flags and
//  loads the configuration defaults; data registers and sine memory hold
//  no reset value. A stalled result holds its stage; bubbles behind it close up.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty #(
  parameter int INDEX_SHIFT = 6,
  parameter int TABLE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [svpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [svpd_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [7:0]                        in_table_index,
  input  logic [svpd_pkg::ENTRY_W-1:0]      in_table_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [svpd_pkg::DUTY_W-1:0]       out_duty_a,
  output logic [svpd_pkg::DUTY_W-1:0]       out_duty_b,
  output logic [svpd_pkg::DUTY_W-1:0]       out_duty_c,
  output logic [svpd_pkg::SEC_W-1:0]        out_sector
);
  import svpd_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  // reduce an angle to a table address; the quotient is below 16
  function automatic logic [AW-1:0] tbl_addr(input logic [PHASE_W-1:0] ang);
    logic [11:0] r;
    r = {4'b0000, 8'(ang >> INDEX_SHIFT)};
    for (int j = 3; j >= 0; j--) begin
      if (r >= 12'(TABLE_DEPTH << j)) begin
        r = r - 12'(TABLE_DEPTH << j);
      end
    end
    return r[AW-1:0];
  endfunction

  // configuration
  logic [PER_W-1:0]   pwm_period_r;
  logic [PHASE_W-1:0] phase_step_r;
  logic [SW_W-1:0]    sector_width_r;
  logic [DUTY_W-1:0]  range_cnt;

  // phase accumulator
  logic [PHASE_W-1:0] phase_acc_r;
  logic [PHASE_W-1:0] phase_nxt;

  // stage A: input register
  logic               a_vld_r;
  logic               a_cmd_r;
  logic [7:0]         a_idx_r;
  logic [ENTRY_W-1:0] a_val_r;
  logic [PHASE_W-1:0] a_phase_r;

  // stage B: memory read data
  logic               b_vld_r;
  logic [SEC_W-1:0]   b_sector_r;
  logic [ENTRY_W-1:0] rd1_r;
  logic [ENTRY_W-1:0] rd2_r;

  // stage C: scaled times
  logic               c_vld_r;
  logic [SEC_W-1:0]   c_sector_r;
  logic [DUTY_W-1:0]  t1_r;
  logic [DUTY_W-1:0]  t2_r;

  // output register
  logic               out_vld_r;
  logic [DUTY_W-1:0]  duty_a_r;
  logic [DUTY_W-1:0]  duty_b_r;
  logic [DUTY_W-1:0]  duty_c_r;
  logic [SEC_W-1:0]   sector_r;

  logic [ENTRY_W-1:0] sine_mem [TABLE_DEPTH];

  logic in_acc;
  logic out_free;
  logic c_free;
  logic b_free;
  logic a_go;
  logic a_free;
  logic b_ld;
  logic c_ld;
  logic d_ld;
  logic mem_we;

  logic [AW-1:0]       addr1;
  logic [AW-1:0]       addr2;
  logic [30:0]         prod1;
  logic [30:0]         prod2;
  sect_ang_t           sect_ang;
  duty_t               duty;

  // handshake chain: a stage loads when it is empty or its content moves on
  assign out_free = !out_vld_r || !out_stall;
  assign d_ld     = c_vld_r && out_free;
  assign c_free   = !c_vld_r || out_free;
  assign c_ld     = b_vld_r && c_free;
  assign b_free   = !b_vld_r || c_free;
  assign a_go     = a_vld_r && (a_cmd_r || b_free);
  assign a_free   = !a_vld_r || a_go;
  assign in_stall = !a_free;
  assign in_acc   = in_valid && a_free;
  assign b_ld     = a_go && !a_cmd_r;
  assign mem_we   = a_go && a_cmd_r && ({1'b0, a_idx_r} < 9'(TABLE_DEPTH));

  assign range_cnt = {pwm_period_r, 1'b0};
  assign phase_nxt = (phase_acc_r < PHASE_LIMIT) ? phase_acc_r + phase_step_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r   <= PER_W'(999);
      phase_step_r   <= PHASE_W'(1000);
      sector_width_r <= SW_W'(10922);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PWM_PERIOD:   pwm_period_r   <= cfg_wr_data[PER_W-1:0];
        CFG_PHASE_STEP:   phase_step_r   <= cfg_wr_data[PHASE_W-1:0];
        CFG_SECTOR_WIDTH: sector_width_r <= cfg_wr_data[SW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
    end else if (in_acc && !in_cmd) begin
      phase_acc_r <= phase_nxt;
    end
  end

  // stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_free) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_cmd_r   <= in_cmd;
      a_idx_r   <= in_table_index;
      a_val_r   <= in_table_value;
      a_phase_r <= phase_nxt;
    end
  end

  svpd_sector u_sector (
    .phase        (a_phase_r),
    .sector_width (sector_width_r),
    .sect_ang     (sect_ang)
  );

  assign addr1 = tbl_addr(sect_ang.ang1);
  assign addr2 = tbl_addr(sect_ang.ang2);

  // sine memory: one write port, two registered read ports, read-old on clash
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sine_mem[a_idx_r[AW-1:0]] <= a_val_r;
    end
    if (b_ld) begin
      rd1_r      <= sine_mem[addr1];
      rd2_r      <= sine_mem[addr2];
      b_sector_r <= sect_ang.sector;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_free) begin
      b_vld_r <= b_ld;
    end
  end

  // stage C: scale by the full duty range
  assign prod1 = 31'(rd1_r) * 31'(range_cnt);
  assign prod2 = 31'(rd2_r) * 31'(range_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_free) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ld) begin
      t1_r       <= prod1[Q15_SHIFT +: DUTY_W];
      t2_r       <= prod2[Q15_SHIFT +: DUTY_W];
      c_sector_r <= b_sector_r;
    end
  end

  svpd_duty u_duty (
    .range_cnt (range_cnt),
    .t1        (t1_r),
    .t2        (t2_r),
    .sector    (c_sector_r),
    .duty      (duty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ld) begin
      duty_a_r <= duty.a;
      duty_b_r <= duty.b;
      duty_c_r <= duty.c;
      sector_r <= c_sector_r;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_duty_a = duty_a_r;
  assign out_duty_b = duty_b_r;
  assign out_duty_c = duty_c_r;
  assign out_sector = sector_r;

  a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (sector_r <= SECTOR_5))
    else $error("result sector out of range");

  a_phase_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_cmd && (phase_acc_r >= PHASE_LIMIT)) |=> (phase_acc_r == '0))
    else $error("phase did not clear at limit");

  a_tick_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (a_vld_r && !a_cmd_r && !b_vld_r) |=> b_vld_r)
    else $error("tick stuck in input register");

endmodule

[rtl/core/svpd_sector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_sector: sector decode and in-sector angles
// Compares the phase against the five sector boundaries at full width and
// forms the two angles used to look up the sine table.
// ----------------------------------------------------------------------------
module svpd_sector (
  input  logic [svpd_pkg::PHASE_W-1:0] phase,
  input  logic [svpd_pkg::SW_W-1:0]    sector_width,
  output svpd_pkg::sect_ang_t          sect_ang
);
  import svpd_pkg::*;

  logic [16:0] bnd1;
  logic [16:0] bnd2;
  logic [16:0] bnd3;
  logic [16:0] bnd4;
  logic [16:0] bnd5;
  logic [16:0] base;
  logic [16:0] ph_ext;
  logic [SEC_W-1:0]   sec;
  logic [PHASE_W-1:0] ang2;

  assign ph_ext = {1'b0, phase};
  assign bnd1   = {3'b000, sector_width};
  assign bnd2   = {2'b00, sector_width, 1'b0};
  assign bnd3   = bnd1 + bnd2;
  assign bnd4   = {1'b0, sector_width, 2'b00};
  assign bnd5   = bnd1 + bnd4;

  // boundaries rise monotonically, so the highest one passed names the sector
  always_comb begin
    if (ph_ext >= bnd5) begin
      sec  = SECTOR_5;
      base = bnd5;
    end else if (ph_ext >= bnd4) begin
      sec  = SECTOR_4;
      base = bnd4;
    end else if (ph_ext >= bnd3) begin
      sec  = SECTOR_3;
      base = bnd3;
    end else if (ph_ext >= bnd2) begin
      sec  = SECTOR_2;
      base = bnd2;
    end else if (ph_ext >= bnd1) begin
      sec  = SECTOR_1;
      base = bnd1;
    end else begin
      sec  = SECTOR_0;
      base = '0;
    end
  end

  assign ang2 = phase - base[PHASE_W-1:0];

  assign sect_ang.sector = sec;
  assign sect_ang.ang2   = ang2;
  assign sect_ang.ang1   = {2'b00, sector_width} - ang2;

endmodule

[rtl/core/svpd_duty.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_duty: centre-aligned duty counts
// Splits the zero-vector time in half and distributes the active times over
// the three phases according to the sector. All sums wrap at 16 bits.
// ----------------------------------------------------------------------------
module svpd_duty (
  input  logic [svpd_pkg::DUTY_W-1:0] range_cnt,
  input  logic [svpd_pkg::DUTY_W-1:0] t1,
  input  logic [svpd_pkg::DUTY_W-1:0] t2,
  input  logic [svpd_pkg::SEC_W-1:0]  sector,
  output svpd_pkg::duty_t             duty
);
  import svpd_pkg::*;

  logic [DUTY_W-1:0] t0;
  logic [DUTY_W-1:0] half;
  logic [DUTY_W-1:0] full;
  logic [DUTY_W-1:0] t1h;
  logic [DUTY_W-1:0] t2h;

  assign t0   = range_cnt - t1 - t2;
  assign half = {1'b0, t0[DUTY_W-1:1]};
  assign t1h  = t1 + half;
  assign t2h  = t2 + half;
  assign full = t1h + t2;

  always_comb begin
    case (sector)
      SECTOR_0: begin
        duty.a = full; duty.b = t2h;  duty.c = half;
      end
      SECTOR_1: begin
        duty.a = t1h;  duty.b = full; duty.c = half;
      end
      SECTOR_2: begin
        duty.a = half; duty.b = full; duty.c = t2h;
      end
      SECTOR_3: begin
        duty.a = half; duty.b = t1h;  duty.c = full;
      end
      SECTOR_4: begin
        duty.a = t2h;  duty.b = half; duty.c = full;
      end
      default: begin
        duty.a = full; duty.b = half; duty.c = t1h;
      end
    endcase
  end

endmodule
